// ----- rtl/core/lprt_pkg.sv -----
package lprt_pkg;

	// operation codes carried in the op field of a command word
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LOOKUP = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// status codes of a result word
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_PLEN = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [7:0]  NO_REGION     = 8'hFF;
	localparam logic [7:0]  V6_MAX_PREFIX = 8'd128;
	localparam logic [7:0]  V4_MAX_PREFIX = 8'd32;
	localparam logic [31:0] V4_MASK       = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic        is_ipv6;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  prefix_len;
		logic [7:0]  region_tag;
	} in_word_t;

	typedef struct packed {
		logic [7:0] region_out;
		logic       matched;
		logic [1:0] status;
	} out_word_t;

	// one stored prefix
	typedef struct packed {
		logic        is_v6;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  prefix;
		logic [7:0]  region;
	} entry_t;

	// lookup probe walking the cell row, with the best match so far
	typedef struct packed {
		logic        valid;
		logic        is_v6;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic        matched;
		logic [7:0]  best_len;
		logic [7:0]  region;
	} probe_t;

endpackage

// ----- rtl/core/lprt_cell.sv -----
module lprt_cell #(
	parameter int ENTRIES = 64,
	parameter int INDEX   = 0
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      wr_en,
	input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_idx,
	input  lprt_pkg::entry_t                          wr_entry,
	input  logic [$clog2(ENTRIES + 1)-1:0]            count,
	input  lprt_pkg::probe_t                          probe_in,
	output lprt_pkg::probe_t                          probe_out
);
	import lprt_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	entry_t      entry_q;
	probe_t      probe_s1;
	probe_t      probe_nxt;
	logic [63:0] mask_hi;
	logic [63:0] mask_lo;
	logic        active;
	logic        hit;

	// hold the entry; written once per insert at this slot
	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IDX_W'(INDEX))) begin
			entry_q <= wr_entry;
		end
	end

	assign active = (CNT_W'(INDEX) < count);

	// prefix mask: bit 127 of the 128-bit address is the top of addr_hi
	always_comb begin
		for (int j = 0; j < 64; j++) begin
			if (entry_q.is_v6) begin
				mask_hi[j] = (8'(63 - j) < entry_q.prefix);
				mask_lo[j] = (8'(127 - j) < entry_q.prefix);
			end else begin
				mask_hi[j] = 1'b0;
				mask_lo[j] = (j < 32) && (8'((31 - j) & 8'hFF) < entry_q.prefix);
			end
		end
	end

	assign hit = active && (entry_q.is_v6 == probe_in.is_v6) &&
		(((entry_q.addr_hi ^ probe_in.addr_hi) & mask_hi) == 64'd0) &&
		(((entry_q.addr_lo ^ probe_in.addr_lo) & mask_lo) == 64'd0);

	// strictly longer wins, so on a tie the earlier slot keeps the match
	always_comb begin
		probe_nxt = probe_in;
		if (hit && (!probe_in.matched || (entry_q.prefix > probe_in.best_len))) begin
			probe_nxt.matched  = 1'b1;
			probe_nxt.best_len = entry_q.prefix;
			probe_nxt.region   = entry_q.region;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_s1 <= '0;
		end else begin
			probe_s1 <= probe_nxt;
		end
	end

	assign probe_out = probe_s1;

endmodule

// ----- rtl/core/longest_prefix_region_table.sv -----
// Longest-prefix region table for IPv4 and IPv6 prefixes.
// Command channel: drive cmd and raise start; the word is taken at a rising
// edge where start is high and busy is low. op selects insert, lookup or clear.
// Result channel: done pulses for exactly one cycle with the result word on
// result; the receiver cannot stall, so the word must be captured that cycle.
// Insert, clear and unknown ops: result in the cycle after accept, busy stays
// low, so such commands may be issued on every cycle.
// Lookup: the probe walks a row of TABLE_ENTRIES cells, one cell per cycle,
// each cell holding one prefix and keeping the longest match so far. The
// probe is registered at launch and again in every cell; busy stays high
// until it leaves the last cell and drops as done pulses, so the next
// command can be taken while the lookup result is shown.
// Reset clears the entry count (empty table), busy and all in-flight probes;
// the stored prefixes themselves are not cleared.
module longest_prefix_region_table #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lprt_pkg::in_word_t  cmd,
	output logic                done,
	output lprt_pkg::out_word_t result
);
	import lprt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	logic             accept;
	logic [CNT_W-1:0] count_q;
	logic             busy_q;
	logic             done_q;
	out_word_t        result_q;
	probe_t           launch_q;
	probe_t           chain [TABLE_ENTRIES+1];
	entry_t           wr_entry;
	logic             wr_en;
	logic             bad_plen;
	logic             full;
	out_word_t        imm_result;

	assign accept = start && !busy_q;

	// insert checks: prefix length first, then capacity
	assign bad_plen = cmd.is_ipv6 && (cmd.prefix_len > V6_MAX_PREFIX);
	assign full     = (count_q == CNT_W'(TABLE_ENTRIES));
	assign wr_en    = accept && (cmd.op == OP_INSERT) && !bad_plen && !full;

	// IPv4 entries drop the upper address bits and clamp the prefix
	always_comb begin
		wr_entry.is_v6  = cmd.is_ipv6;
		wr_entry.region = cmd.region_tag;
		if (cmd.is_ipv6) begin
			wr_entry.addr_hi = cmd.addr_hi;
			wr_entry.addr_lo = cmd.addr_lo;
			wr_entry.prefix  = cmd.prefix_len;
		end else begin
			wr_entry.addr_hi = 64'd0;
			wr_entry.addr_lo = {32'd0, cmd.addr_lo[31:0] & V4_MASK};
			wr_entry.prefix  = (cmd.prefix_len > V4_MAX_PREFIX) ? V4_MAX_PREFIX
				: cmd.prefix_len;
		end
	end

	// result word for the ops other than lookup
	always_comb begin
		imm_result.region_out = NO_REGION;
		imm_result.matched    = 1'b0;
		imm_result.status     = ST_OK;
		if (cmd.op == OP_INSERT) begin
			if (bad_plen) begin
				imm_result.status = ST_BAD_PLEN;
			end else if (full) begin
				imm_result.status = ST_FULL;
			end
		end
	end

	// entry count, busy flag, result strobe and probe launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			launch_q <= '0;
		end else begin
			done_q <= 1'b0;
			// launch a fresh probe with no match yet
			launch_q.valid    <= 1'b0;
			launch_q.is_v6    <= cmd.is_ipv6;
			launch_q.addr_hi  <= cmd.addr_hi;
			launch_q.addr_lo  <= cmd.addr_lo;
			launch_q.matched  <= 1'b0;
			launch_q.best_len <= 8'd0;
			launch_q.region   <= NO_REGION;
			if (accept) begin
				unique case (cmd.op)
					OP_INSERT: begin
						if (wr_en) begin
							count_q <= count_q + CNT_W'(1);
						end
						done_q <= 1'b1;
					end
					OP_LOOKUP: begin
						busy_q         <= 1'b1;
						launch_q.valid <= 1'b1;
					end
					OP_CLEAR: begin
						count_q <= '0;
						done_q  <= 1'b1;
					end
					default: begin
						done_q <= 1'b1;
					end
				endcase
			end
			if (chain[TABLE_ENTRIES].valid) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// capture the result word: lookup from the chain end, others at once
	always_ff @(posedge clk) begin
		if (chain[TABLE_ENTRIES].valid) begin
			result_q.region_out <= chain[TABLE_ENTRIES].region;
			result_q.matched    <= chain[TABLE_ENTRIES].matched;
			result_q.status     <= ST_OK;
		end else if (accept) begin
			result_q <= imm_result;
		end
	end

	assign chain[0] = launch_q;

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		lprt_cell #(
			.ENTRIES(TABLE_ENTRIES),
			.INDEX  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en),
			.wr_idx   (count_q[IDX_W-1:0]),
			.wr_entry (wr_entry),
			.count    (count_q),
			.probe_in (chain[i]),
			.probe_out(chain[i+1])
		);
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	// a result strobe never overlaps a lookup still in flight
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while lookup in flight");

	// a probe leaving the row always belongs to an outstanding lookup
	a_chain_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chain[TABLE_ENTRIES].valid |-> busy_q)
		else $error("probe left the cell row with no lookup pending");

	// the entry count never passes the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count beyond table size");

	// an accepted lookup blocks the command channel on the next cycle
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.op == OP_LOOKUP)) |=> (busy_q && !done_q))
		else $error("lookup accepted without raising busy");

endmodule
